>>> design/puw_pkg.sv
// ============================================================================
// puw_pkg - polar unwarp shared definitions
// Field widths, register indexes, parameter defaults and the quarter-wave
// sine table generator used by the coordinate pipeline.
// ============================================================================
package puw_pkg;

	// Parameter defaults
	localparam int SINE_TABLE_BITS_DEF = 10;
	localparam int MAX_OUT_WIDTH_DEF   = 2048;
	localparam int MAX_OUT_HEIGHT_DEF  = 512;

	// Field widths
	localparam int DST_X_W    = 11;
	localparam int DST_Y_W    = 9;
	localparam int SRC_W      = 21;
	localparam int CENTER_W   = 12;
	localparam int RADIUS_W   = 11;
	localparam int STEP_W     = 24;
	localparam int ANGLE_W    = 24;
	localparam int TRIG_W     = 15;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_X     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RADIUS_INNER = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RADIUS_STEP  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ANGLE_OFFSET = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ANGLE_STEP   = 3'd5;

	// Register reset values
	localparam logic [CENTER_W-1:0] CENTER_X_RST     = 12'd512;
	localparam logic [CENTER_W-1:0] CENTER_Y_RST     = 12'd384;
	localparam logic [RADIUS_W-1:0] RADIUS_INNER_RST = 11'd50;
	localparam logic [STEP_W-1:0]   RADIUS_STEP_RST  = 24'd36044;
	localparam logic [ANGLE_W-1:0]  ANGLE_OFFSET_RST = 24'd0;
	localparam logic [ANGLE_W-1:0]  ANGLE_STEP_RST   = 24'd11651;

	// pi/2 in Q2.30
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	// Saturation limits of the source coordinates
	localparam int OUT_MAX = 1048575;
	localparam int OUT_MIN = -1048576;

	// Taylor term divide, (2k)(2k+1) for k = 1..8
	function automatic logic [63:0] taylor_div(input logic [63:0] term, input int unsigned k);
		logic [63:0] res;
		res = term;
		unique case (k)
			1: res = term / 64'd6;
			2: res = term / 64'd20;
			3: res = term / 64'd42;
			4: res = term / 64'd72;
			5: res = term / 64'd110;
			6: res = term / 64'd156;
			7: res = term / 64'd210;
			8: res = term / 64'd272;
			default: res = term;
		endcase
		return res;
	endfunction

	// Table entry i: sin(pi/2 * i / 2^bits) in Q0.15, evaluated at elaboration
	function automatic logic [TRIG_W-1:0] sine_entry(input int unsigned idx,
		input int unsigned bits);
		logic [63:0]        x;
		logic [63:0]        term;
		logic signed [63:0] sum;
		logic [63:0]        q15;
		x    = (64'(idx) * HALF_PI_Q30) >> bits;
		term = x;
		sum  = signed'(x);
		for (int unsigned k = 1; k <= 8; k++) begin
			term = (term * x) >> 30;
			term = (term * x) >> 30;
			term = taylor_div(term, k);
			if (k[0])
				sum = sum - signed'(term);
			else
				sum = sum + signed'(term);
		end
		if (sum < 0)
			sum = 64'sd0;
		q15 = (unsigned'(sum) + 64'd16384) >> 15;
		if (q15 > 64'd32767)
			q15 = 64'd32767;
		return q15[TRIG_W-1:0];
	endfunction

endpackage

>>> design/puw_if.sv
// ============================================================================
// puw_if - polar unwarp channel interfaces
// Pixel position input, source coordinate output and register write channel.
// ============================================================================

// Output pixel position channel
interface puw_in_if import puw_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [DST_X_W-1:0] dst_x;
	logic [DST_Y_W-1:0] dst_y;

	modport source (output valid, output dst_x, output dst_y, input ready);
	modport sink   (input valid, input dst_x, input dst_y, output ready);
endinterface

// Source coordinate channel
interface puw_out_if import puw_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [SRC_W-1:0] src_x;
	logic signed [SRC_W-1:0] src_y;

	modport source (output valid, output src_x, output src_y, input ready);
	modport sink   (input valid, input src_x, input src_y, output ready);
endinterface

// Register write channel
interface puw_cfg_if import puw_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

>>> design/puw_sine_rom.sv
// ============================================================================
// puw_sine_rom - quarter-wave sine table, two registered read ports
// Entries 0..2^TABLE_BITS hold sin(pi/2 * i / 2^TABLE_BITS) in Q0.15.
// ============================================================================
module puw_sine_rom import puw_pkg::*; #(
	parameter int TABLE_BITS = SINE_TABLE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  en,
	input  logic [TABLE_BITS:0]   addr_a,
	input  logic [TABLE_BITS:0]   addr_b,
	output logic [TRIG_W-1:0]     data_a,
	output logic [TRIG_W-1:0]     data_b
);

	localparam int DEPTH = (1 << TABLE_BITS) + 1;

	logic [TRIG_W-1:0] rom_w [DEPTH];
	logic [TRIG_W-1:0] data_a_s5;
	logic [TRIG_W-1:0] data_b_s5;

	// Constant table contents
	for (genvar g = 0; g < DEPTH; g++) begin : g_rom
		localparam logic [TRIG_W-1:0] ENTRY = sine_entry(g, TABLE_BITS);
		assign rom_w[g] = ENTRY;
	end

	// Registered lookup, held while the stage is stalled
	always_ff @(posedge clk) begin
		if (en) begin
			data_a_s5 <= rom_w[addr_a];
			data_b_s5 <= rom_w[addr_b];
		end
	end

	assign data_a = data_a_s5;
	assign data_b = data_b_s5;

endmodule

>>> design/polar_unwarp_coordinate_generator_top.sv
// ============================================================================
// polar_unwarp_coordinate_generator_top - panorama to ring image mapping
// Maps each panorama pixel position to its source position in the ring image.
// ============================================================================
// The block takes one panorama pixel position per clock and returns its
// source position in the ring image from the last stage, at one result per
// clock for as long as the sink keeps ready high. The eight register stages
// are: position clamp, radius and angle step multiplies, radius and angle
// sums, sine table addressing, table lookup, radius times cosine and sine,
// rounding to 1/256 pixel, and center add with saturation. Each stage holds
// its beat independently, so bubbles close up under backpressure and the
// input stalls only when every stage is full. Register writes are taken every
// cycle and should only be issued with the pipeline empty.
module polar_unwarp_coordinate_generator_top import puw_pkg::*; #(
	parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF,
	parameter int MAX_OUT_WIDTH   = MAX_OUT_WIDTH_DEF,
	parameter int MAX_OUT_HEIGHT  = MAX_OUT_HEIGHT_DEF
) (
	input logic   clk,
	input logic   arst_n,
	puw_in_if.sink    pix_in,
	puw_out_if.source pix_out,
	puw_cfg_if.sink   cfg
);

	localparam int B       = SINE_TABLE_BITS;
	localparam int ADDR_W  = B + 1;
	localparam int PHASE_W = B + 2;
	localparam int R_W     = 34;
	localparam int YD_W    = 33;
	localparam int P_W     = R_W + TRIG_W;
	localparam int SP_W    = P_W + 2;
	localparam int OFF_W   = SP_W - 23;
	localparam int SUM_W   = OFF_W + 1;

	localparam int X_SPAN = 1 << DST_X_W;
	localparam int Y_SPAN = 1 << DST_Y_W;
	localparam int X_LIM  = (MAX_OUT_WIDTH < X_SPAN) ? MAX_OUT_WIDTH : X_SPAN;
	localparam int Y_LIM  = (MAX_OUT_HEIGHT < Y_SPAN) ? MAX_OUT_HEIGHT : Y_SPAN;
	localparam logic [DST_X_W-1:0] X_MAX = DST_X_W'(X_LIM - 1);
	localparam logic [DST_Y_W-1:0] Y_MAX = DST_Y_W'(Y_LIM - 1);
	localparam logic [ADDR_W-1:0]  ROM_N = ADDR_W'(1) << B;

	localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(OUT_MAX);
	localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(OUT_MIN);

	// Configuration registers
	logic [CENTER_W-1:0] center_x_q;
	logic [CENTER_W-1:0] center_y_q;
	logic [RADIUS_W-1:0] radius_inner_q;
	logic [STEP_W-1:0]   radius_step_q;
	logic [ANGLE_W-1:0]  angle_offset_q;
	logic [ANGLE_W-1:0]  angle_step_q;

	// Stage valids and advance enables
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8;
	logic adv_s1, adv_s2, adv_s3, adv_s4, adv_s5, adv_s6, adv_s7, adv_s8;

	// Stage payloads
	logic [DST_X_W-1:0]      dx_s1;
	logic [DST_Y_W-1:0]      dy_s1;
	logic [YD_W-1:0]         ydelta_s2;
	logic [ANGLE_W-1:0]      xang_s2;
	logic [R_W-1:0]          r_s3;
	logic [ANGLE_W-1:0]      ang_s3;
	logic [R_W-1:0]          r_s4;
	logic [ADDR_W-1:0]       addr_cos_s4;
	logic [ADDR_W-1:0]       addr_sin_s4;
	logic                    neg_cos_s4;
	logic                    neg_sin_s4;
	logic [R_W-1:0]          r_s5;
	logic                    neg_cos_s5;
	logic                    neg_sin_s5;
	logic [P_W-1:0]          prod_x_s6;
	logic [P_W-1:0]          prod_y_s6;
	logic                    neg_cos_s6;
	logic                    neg_sin_s6;
	logic signed [OFF_W-1:0] off_x_s7;
	logic signed [OFF_W-1:0] off_y_s7;
	logic signed [SRC_W-1:0] src_x_s8;
	logic signed [SRC_W-1:0] src_y_s8;

	// Combinational helpers
	logic [DST_X_W-1:0]      dx_clamp;
	logic [DST_Y_W-1:0]      dy_clamp;
	logic [PHASE_W-1:0]      phase;
	logic [1:0]              quad_sin;
	logic [1:0]              quad_cos;
	logic [B-1:0]            frac;
	logic [ADDR_W-1:0]       addr_fwd;
	logic [ADDR_W-1:0]       addr_rev;
	logic [TRIG_W-1:0]       trig_cos;
	logic [TRIG_W-1:0]       trig_sin;
	logic signed [SP_W-1:0]  sp_x;
	logic signed [SP_W-1:0]  sp_y;
	logic signed [SP_W-1:0]  rnd_x;
	logic signed [SP_W-1:0]  rnd_y;
	logic signed [SUM_W-1:0] sum_x;
	logic signed [SUM_W-1:0] sum_y;

	// Register writes, never stalled
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q     <= CENTER_X_RST;
			center_y_q     <= CENTER_Y_RST;
			radius_inner_q <= RADIUS_INNER_RST;
			radius_step_q  <= RADIUS_STEP_RST;
			angle_offset_q <= ANGLE_OFFSET_RST;
			angle_step_q   <= ANGLE_STEP_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_CENTER_X:     center_x_q     <= cfg.data[CENTER_W-1:0];
				REG_CENTER_Y:     center_y_q     <= cfg.data[CENTER_W-1:0];
				REG_RADIUS_INNER: radius_inner_q <= cfg.data[RADIUS_W-1:0];
				REG_RADIUS_STEP:  radius_step_q  <= cfg.data[STEP_W-1:0];
				REG_ANGLE_OFFSET: angle_offset_q <= cfg.data[ANGLE_W-1:0];
				REG_ANGLE_STEP:   angle_step_q   <= cfg.data[ANGLE_W-1:0];
				default: ;
			endcase
		end
	end

	// Per-stage flow control: a stage moves when empty or when the next one moves
	assign adv_s8 = !vld_s8 || pix_out.ready;
	assign adv_s7 = !vld_s7 || adv_s8;
	assign adv_s6 = !vld_s6 || adv_s7;
	assign adv_s5 = !vld_s5 || adv_s6;
	assign adv_s4 = !vld_s4 || adv_s5;
	assign adv_s3 = !vld_s3 || adv_s4;
	assign adv_s2 = !vld_s2 || adv_s3;
	assign adv_s1 = !vld_s1 || adv_s2;
	assign pix_in.ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else begin
			if (adv_s1) vld_s1 <= pix_in.valid;
			if (adv_s2) vld_s2 <= vld_s1;
			if (adv_s3) vld_s3 <= vld_s2;
			if (adv_s4) vld_s4 <= vld_s3;
			if (adv_s5) vld_s5 <= vld_s4;
			if (adv_s6) vld_s6 <= vld_s5;
			if (adv_s7) vld_s7 <= vld_s6;
			if (adv_s8) vld_s8 <= vld_s7;
		end
	end

	// S1: clamp position to the panorama size
	assign dx_clamp = (pix_in.dst_x > X_MAX) ? X_MAX : pix_in.dst_x;
	assign dy_clamp = (pix_in.dst_y > Y_MAX) ? Y_MAX : pix_in.dst_y;

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			dx_s1 <= dx_clamp;
			dy_s1 <= dy_clamp;
		end
	end

	// S2: row and column step multiplies (angle kept modulo one turn)
	always_ff @(posedge clk) begin
		if (adv_s2) begin
			ydelta_s2 <= YD_W'(dy_s1) * YD_W'(radius_step_q);
			xang_s2   <= ANGLE_W'(dx_s1) * angle_step_q;
		end
	end

	// S3: radius in Q.16 and wrapped angle
	always_ff @(posedge clk) begin
		if (adv_s3) begin
			r_s3   <= {7'd0, radius_inner_q, 16'd0} + R_W'(ydelta_s2);
			ang_s3 <= angle_offset_q + xang_s2;
		end
	end

	// S4: phase to table address and sign; cosine is a quarter turn ahead
	assign phase    = ang_s3[ANGLE_W-1 -: PHASE_W];
	assign quad_sin = phase[PHASE_W-1 -: 2];
	assign quad_cos = quad_sin + 2'd1;
	assign frac     = phase[B-1:0];
	assign addr_fwd = {1'b0, frac};
	assign addr_rev = ROM_N - {1'b0, frac};

	always_ff @(posedge clk) begin
		if (adv_s4) begin
			r_s4        <= r_s3;
			addr_sin_s4 <= quad_sin[0] ? addr_rev : addr_fwd;
			addr_cos_s4 <= quad_cos[0] ? addr_rev : addr_fwd;
			neg_sin_s4  <= quad_sin[1];
			neg_cos_s4  <= quad_cos[1];
		end
	end

	// S5: table lookup
	puw_sine_rom #(
		.TABLE_BITS (SINE_TABLE_BITS)
	) u_rom (
		.clk    (clk),
		.en     (adv_s5),
		.addr_a (addr_cos_s4),
		.addr_b (addr_sin_s4),
		.data_a (trig_cos),
		.data_b (trig_sin)
	);

	always_ff @(posedge clk) begin
		if (adv_s5) begin
			r_s5       <= r_s4;
			neg_cos_s5 <= neg_cos_s4;
			neg_sin_s5 <= neg_sin_s4;
		end
	end

	// S6: radius times magnitude of cosine and sine
	always_ff @(posedge clk) begin
		if (adv_s6) begin
			prod_x_s6  <= P_W'(r_s5) * P_W'(trig_cos);
			prod_y_s6  <= P_W'(r_s5) * P_W'(trig_sin);
			neg_cos_s6 <= neg_cos_s5;
			neg_sin_s6 <= neg_sin_s5;
		end
	end

	// S7: apply sign, round half up to 1/256 pixel (floor of the biased value)
	assign sp_x  = neg_cos_s6 ? -signed'({2'b00, prod_x_s6}) : signed'({2'b00, prod_x_s6});
	assign sp_y  = neg_sin_s6 ? -signed'({2'b00, prod_y_s6}) : signed'({2'b00, prod_y_s6});
	assign rnd_x = sp_x + (SP_W'(1) <<< 22);
	assign rnd_y = sp_y + (SP_W'(1) <<< 22);

	always_ff @(posedge clk) begin
		if (adv_s7) begin
			off_x_s7 <= rnd_x[SP_W-1:23];
			off_y_s7 <= rnd_y[SP_W-1:23];
		end
	end

	// S8: add center and saturate
	assign sum_x = signed'(SUM_W'({center_x_q, 8'd0})) + SUM_W'(off_x_s7);
	assign sum_y = signed'(SUM_W'({center_y_q, 8'd0})) + SUM_W'(off_y_s7);

	always_ff @(posedge clk) begin
		if (adv_s8) begin
			if (sum_x > SAT_HI)
				src_x_s8 <= SRC_W'(SAT_HI);
			else if (sum_x < SAT_LO)
				src_x_s8 <= SRC_W'(SAT_LO);
			else
				src_x_s8 <= sum_x[SRC_W-1:0];
			if (sum_y > SAT_HI)
				src_y_s8 <= SRC_W'(SAT_HI);
			else if (sum_y < SAT_LO)
				src_y_s8 <= SRC_W'(SAT_LO);
			else
				src_y_s8 <= sum_y[SRC_W-1:0];
		end
	end

	assign pix_out.valid = vld_s8;
	assign pix_out.src_x = src_x_s8;
	assign pix_out.src_y = src_y_s8;

endmodule

>>> design/puw_checker.sv
// ============================================================================
// puw_checker - port level checks for the polar unwarp block
// Output handshake, backpressure-only input stall, reset and register port.
// ============================================================================
module puw_checker import puw_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_ready,
	input logic                    out_valid,
	input logic                    out_ready,
	input logic signed [SRC_W-1:0] src_x,
	input logic signed [SRC_W-1:0] src_y,
	input logic                    cfg_ready
);

	// A result beat that is not taken stays
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat dropped while stalled");

	// ... with its coordinates unchanged
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(src_x) && $stable(src_y))
		else $error("result beat changed while stalled");

	// Input only stalls when a finished result is waiting on the sink
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without output backpressure");

	// No result right out of reset
	a_reset_empty: assert property (@(posedge clk)
		!arst_n || $rose(arst_n) |-> !out_valid)
		else $error("result valid during reset");

	// Register port never stalls
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid || !in_valid |-> cfg_ready)
		else $error("register port not ready");

endmodule

bind polar_unwarp_coordinate_generator_top puw_checker u_puw_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (pix_in.valid),
	.in_ready  (pix_in.ready),
	.out_valid (pix_out.valid),
	.out_ready (pix_out.ready),
	.src_x     (pix_out.src_x),
	.src_y     (pix_out.src_y),
	.cfg_ready (cfg.ready)
);
